[rtl/dvru_pkg.sv]
// shared types, constants and helpers for the distance-vector route update block
package dvru_pkg;

    // table geometry and cost limits
    localparam int TABLE_DEPTH = 32;
    localparam int COST_W      = 5;
    localparam int ADDR_W      = 32;
    localparam int SLOT_W      = 5;
    localparam int OUTCOME_W   = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COST_W-1:0] COST_LIMIT = 5'd15;
    localparam logic [COST_W-1:0] COST_CAP   = 5'd16;
    localparam logic [COST_W-1:0] COST_SELF  = 5'd1;

    // result outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED  = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_UPDATED   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_UNCHANGED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_DROPPED   = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_A  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_B  = 2'd2;

    // one route table slot
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] next_hop;
        logic [ADDR_W-1:0] iface;
        logic [COST_W-1:0] cost;
    } t_entry;

    // one advertised route as held during the search
    typedef struct packed {
        logic [ADDR_W-1:0] neighbor_addr;
        logic [ADDR_W-1:0] receive_iface;
        logic [ADDR_W-1:0] adv_dest;
        logic [COST_W-1:0] adv_cost;
        logic [ADDR_W-1:0] adv_iface;
        logic              dest_is_local;
    } t_item;

    // one result item
    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    entry_index;
        logic [COST_W-1:0]    entry_cost;
        logic [ADDR_W-1:0]    entry_next_hop;
    } t_result;

    // hop count plus one, saturating at the unreachable cost
    function automatic logic [COST_W-1:0] cost_plus_one(input logic [COST_W-1:0] cost);
        logic [COST_W-1:0] sum;
        sum = cost + 5'd1;
        return (cost >= COST_LIMIT) ? COST_CAP : sum;
    endfunction

endpackage

[rtl/dvru_route_if.sv]
// input channel carrying one advertised route per transfer
interface dvru_route_if;
    logic                           valid;
    logic                           ready;
    logic [dvru_pkg::ADDR_W-1:0]    neighbor_addr;
    logic [dvru_pkg::ADDR_W-1:0]    receive_iface;
    logic [dvru_pkg::ADDR_W-1:0]    adv_dest;
    logic [dvru_pkg::COST_W-1:0]    adv_cost;
    logic [dvru_pkg::ADDR_W-1:0]    adv_iface;
    logic                           dest_is_local;
    logic                           first_of_message;

    modport source (
        output valid, neighbor_addr, receive_iface, adv_dest, adv_cost, adv_iface,
               dest_is_local, first_of_message,
        input  ready
    );
    modport sink (
        input  valid, neighbor_addr, receive_iface, adv_dest, adv_cost, adv_iface,
               dest_is_local, first_of_message,
        output ready
    );
endinterface

[rtl/dvru_result_if.sv]
// output channel carrying one update result per transfer
interface dvru_result_if;
    logic                           valid;
    logic                           ready;
    logic [dvru_pkg::OUTCOME_W-1:0] outcome;
    logic [dvru_pkg::SLOT_W-1:0]    entry_index;
    logic [dvru_pkg::COST_W-1:0]    entry_cost;
    logic [dvru_pkg::ADDR_W-1:0]    entry_next_hop;

    modport source (
        output valid, outcome, entry_index, entry_cost, entry_next_hop,
        input  ready
    );
    modport sink (
        input  valid, outcome, entry_index, entry_cost, entry_next_hop,
        output ready
    );
endinterface

[rtl/dvru_cfg_if.sv]
// configuration write channel: register index and write data
interface dvru_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dvru_pkg::CFG_IDX_W-1:0] index;
    logic [dvru_pkg::ADDR_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/distance_vector_route_update_top.sv]
// top level of the distance-vector route update block
//
// i_route takes one advertised route per transfer (valid/ready). The block
// searches its route table memory for the destination, one slot per cycle,
// then inserts, relaxes or overwrites the entry and offers one result on
// o_result. i_cfg writes relax_mode (index 0) and the two blocked neighbor
// addresses (indexes 1 and 2); it is always ready.
// One item at a time: i_route.ready is high only while the sequencer is idle.
// The scan steps through the slots below the route count in order, through
// the single read port of the table memory. An item that arrives while the
// drop flag is set, not first of its message, skips the scan and is dropped.
// i_route.ready returns as the result is loaded into the output register.
// The result sits in an output register; a new item is taken while it waits,
// and that item's result is held back until the receiver takes the old one.
// Synchronous reset clears the route count, the drop flag and the sequencer,
// and sets relax_mode to 1 and both blocked addresses to 0. Table contents
// are not cleared: only slots below the route count are ever read.
// Write and read of the table never overlap, since the write happens after
// the scan of the item has finished.
module distance_vector_route_update_top #(
    parameter int TABLE_DEPTH = dvru_pkg::TABLE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dvru_route_if.sink    i_route,
    dvru_result_if.source o_result,
    dvru_cfg_if.sink      i_cfg
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                   r_state;
    logic                         r_relax;
    logic [dvru_pkg::ADDR_W-1:0]  r_blk_a;
    logic [dvru_pkg::ADDR_W-1:0]  r_blk_b;
    logic [CNT_W-1:0]             r_count;
    logic                         r_drop;
    dvru_pkg::t_item              r_item;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_cmp_v;
    logic [IDX_W-1:0]             r_cmp_idx;
    logic                         r_hit;
    logic [IDX_W-1:0]             r_slot;
    dvru_pkg::t_result            r_res;
    dvru_pkg::t_result            r_out;
    logic                         r_out_v;

    logic                         w_in_xfer;
    logic                         w_out_xfer;
    logic                         w_cfg_xfer;
    logic                         w_hit;
    logic                         w_more;
    logic                         w_rd_en;
    dvru_pkg::t_entry             w_rd;
    logic                         w_write;
    dvru_pkg::t_entry             w_wr_data;
    dvru_pkg::t_result            w_res;
    logic                         w_set_drop;
    logic                         w_inc_count;
    logic [dvru_pkg::COST_W-1:0]  w_cost;
    logic [dvru_pkg::ADDR_W-1:0]  w_hop;
    logic                         w_full;
    logic                         w_blocked;

    // handshakes
    assign i_route.ready = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign w_in_xfer     = i_route.valid && i_route.ready;
    assign w_out_xfer    = o_result.valid && o_result.ready;
    assign w_cfg_xfer    = i_cfg.valid && i_cfg.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax <= 1'b1;
            r_blk_a <= '0;
            r_blk_b <= '0;
        end else if (w_cfg_xfer) begin
            unique case (i_cfg.index)
                dvru_pkg::CFG_RELAX_MODE: r_relax <= i_cfg.data[0];
                dvru_pkg::CFG_BLOCKED_A:  r_blk_a <= i_cfg.data;
                dvru_pkg::CFG_BLOCKED_B:  r_blk_b <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // scan: compare the slot read last cycle, issue the next read unless it matched
    assign w_hit   = (r_state == S_SCAN) && r_cmp_v && (w_rd.dest == r_item.adv_dest);
    assign w_more  = (r_idx < r_count);
    assign w_rd_en = (r_state == S_SCAN) && !w_hit && w_more;

    dvru_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (w_rd),
        .i_wr_en   (w_write),
        .i_wr_addr (r_slot),
        .i_wr_data (w_wr_data)
    );

    // modify step: new entry contents and the result
    assign w_cost    = dvru_pkg::cost_plus_one(r_item.adv_cost);
    assign w_hop     = (w_cost < dvru_pkg::COST_CAP) ? r_item.adv_iface : w_rd.next_hop;
    assign w_full    = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_blocked = (r_item.neighbor_addr == r_blk_a) ||
                       (r_item.neighbor_addr == r_blk_b);

    always_comb begin
        logic wr;
        wr          = 1'b0;
        w_wr_data   = w_rd;
        w_res       = '0;
        w_set_drop  = 1'b0;
        w_inc_count = 1'b0;
        w_res.entry_index    = dvru_pkg::SLOT_W'(r_slot);
        w_res.entry_cost     = w_rd.cost;
        w_res.entry_next_hop = w_rd.next_hop;
        priority if (!r_hit) begin
            if (w_full) begin
                w_res         = '0;
                w_res.outcome = dvru_pkg::OUT_FULL;
            end else begin
                wr                 = 1'b1;
                w_inc_count        = 1'b1;
                w_wr_data.dest     = r_item.adv_dest;
                w_wr_data.next_hop = r_item.neighbor_addr;
                w_wr_data.iface    = r_item.receive_iface;
                w_wr_data.cost     = (r_item.neighbor_addr == r_item.adv_dest)
                                   ? dvru_pkg::COST_SELF : w_cost;
                w_res.outcome        = dvru_pkg::OUT_INSERTED;
                w_res.entry_cost     = w_wr_data.cost;
                w_res.entry_next_hop = w_wr_data.next_hop;
            end
        end else if (r_relax) begin
            if (w_cost < w_rd.cost) begin
                wr                 = 1'b1;
                w_wr_data.cost     = w_cost;
                w_wr_data.next_hop = r_item.neighbor_addr;
                w_wr_data.iface    = r_item.receive_iface;
                w_res.outcome        = dvru_pkg::OUT_UPDATED;
                w_res.entry_cost     = w_cost;
                w_res.entry_next_hop = r_item.neighbor_addr;
            end else begin
                w_res.outcome = dvru_pkg::OUT_UNCHANGED;
            end
        end else if (w_blocked) begin
            w_set_drop    = 1'b1;
            w_res         = '0;
            w_res.outcome = dvru_pkg::OUT_DROPPED;
        end else if (r_item.dest_is_local) begin
            w_res.outcome = dvru_pkg::OUT_UNCHANGED;
        end else begin
            wr                 = 1'b1;
            w_wr_data.cost     = w_cost;
            w_wr_data.next_hop = w_hop;
            w_res.outcome      = ((w_cost != w_rd.cost) || (w_hop != w_rd.next_hop))
                               ? dvru_pkg::OUT_UPDATED : dvru_pkg::OUT_UNCHANGED;
            w_res.entry_cost     = w_cost;
            w_res.entry_next_hop = w_hop;
        end
        w_write = wr && (r_state == S_MOD);
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_cmp_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_idx   <= '0;
                        r_cmp_v <= 1'b0;
                        if (i_route.first_of_message) begin
                            r_drop <= 1'b0;
                        end
                        if (r_drop && !i_route.first_of_message) begin
                            r_res   <= '{outcome: dvru_pkg::OUT_DROPPED, default: '0};
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    priority if (w_hit) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_cmp_idx;
                        r_state <= S_MOD;
                    end else if (w_more) begin
                        r_cmp_v   <= 1'b1;
                        r_cmp_idx <= r_idx[IDX_W-1:0];
                        r_idx     <= r_idx + CNT_W'(1);
                    end else begin
                        r_hit   <= 1'b0;
                        r_slot  <= r_count[IDX_W-1:0];
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_res   <= w_res;
                    r_state <= S_EMIT;
                    if (w_set_drop) begin
                        r_drop <= 1'b1;
                    end
                    if (w_inc_count) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (!r_out_v || w_out_xfer) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item.neighbor_addr <= i_route.neighbor_addr;
            r_item.receive_iface <= i_route.receive_iface;
            r_item.adv_dest      <= i_route.adv_dest;
            r_item.adv_cost      <= i_route.adv_cost;
            r_item.adv_iface     <= i_route.adv_iface;
            r_item.dest_is_local <= i_route.dest_is_local;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((r_state == S_EMIT) && (!r_out_v || w_out_xfer)) begin
            r_out_v <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && (!r_out_v || w_out_xfer)) begin
            r_out <= r_res;
        end
    end

    assign o_result.valid          = r_out_v;
    assign o_result.outcome        = r_out.outcome;
    assign o_result.entry_index    = r_out.entry_index;
    assign o_result.entry_cost     = r_out.entry_cost;
    assign o_result.entry_next_hop = r_out.entry_next_hop;

endmodule

[rtl/dvru_table.sv]
// route table memory: one write port, one read port with registered read data
module dvru_table #(
    parameter int TABLE_DEPTH = dvru_pkg::TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output dvru_pkg::t_entry               o_rd_data,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  dvru_pkg::t_entry               i_wr_data
);

    dvru_pkg::t_entry r_mem [TABLE_DEPTH];
    dvru_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/dvru_checker.sv]
// port-level checks for the route update block, bound to the top level
module dvru_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [dvru_pkg::OUTCOME_W-1:0] i_outcome,
    input logic [dvru_pkg::SLOT_W-1:0]    i_entry_index,
    input logic [dvru_pkg::COST_W-1:0]    i_entry_cost,
    input logic [dvru_pkg::ADDR_W-1:0]    i_entry_next_hop
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_outcome) && $stable(i_entry_index) &&
            $stable(i_entry_cost) && $stable(i_entry_next_hop))
        else $error("result payload changed while stalled");

    // one item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // dropped and full results carry no slot contents
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_outcome == dvru_pkg::OUT_DROPPED) ||
                        (i_outcome == dvru_pkg::OUT_FULL)) |->
            (i_entry_index == '0) && (i_entry_cost == '0) && (i_entry_next_hop == '0))
        else $error("dropped or full result with slot contents");

    // a touched slot always holds a cost from 1 to the unreachable cost
    a_cost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_outcome == dvru_pkg::OUT_INSERTED) ||
                        (i_outcome == dvru_pkg::OUT_UPDATED) ||
                        (i_outcome == dvru_pkg::OUT_UNCHANGED)) |->
            (i_entry_cost != '0) && (i_entry_cost <= dvru_pkg::COST_CAP))
        else $error("slot cost out of range");

endmodule

bind distance_vector_route_update_top dvru_checker u_dvru_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_route.valid),
    .i_in_ready       (i_route.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_outcome        (o_result.outcome),
    .i_entry_index    (o_result.entry_index),
    .i_entry_cost     (o_result.entry_cost),
    .i_entry_next_hop (o_result.entry_next_hop)
);
